// ----- hw/rtl/smbs_pkg.sv -----
package smbs_pkg;

    // default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // fixed field widths
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int MASS_W  = 31;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // input tdata field offsets
    localparam int S_INDEX_LSB = 0;
    localparam int S_MASS_LSB  = S_INDEX_LSB + INDEX_W;
    localparam int S_KEY_LSB   = S_MASS_LSB + MASS_W;
    localparam int S_MODE_BIT  = S_KEY_LSB + MASS_W;

    // register port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

    // item kinds and search modes
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;
    localparam logic MODE_FLOOR   = 1'b0;
    localparam logic MODE_CEILING = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic                 is_query;
        logic                 wr_ok;
        logic [INDEX_W-1:0]   index;
        logic [MASS_W-1:0]    value;
        logic                 ceiling;
    } smbs_cmd_t;

    // search engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FLOOR,
        ST_EMIT
    } smbs_state_t;

endpackage

// ----- hw/rtl/smbs_front.sv -----
module smbs_front
    import smbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, write_mass, search_key, search_mode (from bit 0 up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                 s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output smbs_cmd_t            cmd
);

    smbs_cmd_t   q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    logic [31:0] index_wide;
    smbs_cmd_t   incoming;

    // classify the incoming item
    always_comb begin
        index_wide        = 32'(s_tdata[S_INDEX_LSB +: INDEX_W]);
        incoming.is_query = (s_tuser == CMD_QUERY);
        incoming.wr_ok    = (index_wide < 32'(TABLE_DEPTH));
        incoming.index    = s_tdata[S_INDEX_LSB +: INDEX_W];
        incoming.value    = (s_tuser == CMD_QUERY) ? s_tdata[S_KEY_LSB +: MASS_W]
                                                   : s_tdata[S_MASS_LSB +: MASS_W];
        incoming.ceiling  = (s_tdata[S_MODE_BIT] == MODE_CEILING);
    end

    // two-entry queue towards the search engine
    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- hw/rtl/smbs_back.sv -----
module smbs_back
    import smbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  smbs_cmd_t            cmd,
    input  logic [COUNT_W-1:0]   entry_count,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found, match_index (from bit 0 up)
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    logic [MASS_W-1:0]  mem [TABLE_DEPTH];
    logic [MASS_W-1:0]  rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               mem_we;

    smbs_state_t        state_reg, state_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [MASS_W-1:0]  key_reg, key_next;
    logic               ceil_reg, ceil_next;
    logic               res_found_reg, res_found_next;
    logic [AW-1:0]      res_idx_reg, res_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [INDEX_W-1:0] m_idx_reg, m_idx_next;

    logic [31:0]        count_wide;
    logic [31:0]        windex_wide;
    logic [31:0]        ridx_wide;
    logic [CW-1:0]      n_sat;
    logic               go_low;
    logic [CW-1:0]      mid1;
    logic [CW-1:0]      mid_a, mid_b;
    logic               more_a, more_b;
    logic [CW-1:0]      new_lo, new_hi, new_mid;
    logic               more;
    logic [CW-1:0]      last_le;

    // clamp the searched count to the table size
    always_comb begin
        count_wide  = 32'(entry_count);
        n_sat       = (count_wide < 32'(TABLE_DEPTH)) ? count_wide[CW-1:0]
                                                      : CW'(TABLE_DEPTH);
        windex_wide = 32'(cmd.index);
        wr_addr     = windex_wide[AW-1:0];
        ridx_wide   = 32'(res_idx_reg);
    end

    // both possible next intervals, chosen by the compare
    always_comb begin
        go_low  = ceil_reg ? (rdata_reg >= key_reg) : (rdata_reg > key_reg);
        mid1    = mid_reg + CW'(1);
        mid_a   = lo_reg + ((mid_reg - lo_reg) >> 1);
        more_a  = (lo_reg < mid_reg);
        mid_b   = mid1 + ((hi_reg - mid1) >> 1);
        more_b  = (mid1 < hi_reg);
        new_lo  = go_low ? lo_reg : mid1;
        new_hi  = go_low ? mid_reg : hi_reg;
        new_mid = go_low ? mid_a : mid_b;
        more    = go_low ? more_a : more_b;
        last_le = new_lo - CW'(1);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        n_next         = n_reg;
        key_next       = key_reg;
        ceil_next      = ceil_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = mid_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (!cmd.is_query) begin
                        mem_we = cmd.wr_ok;
                    end else begin
                        lo_next        = '0;
                        hi_next        = n_sat;
                        n_next         = n_sat;
                        mid_next       = n_sat >> 1;
                        key_next       = cmd.value;
                        ceil_next      = cmd.ceiling;
                        res_found_next = 1'b0;
                        res_idx_next   = '0;
                        rd_addr        = mid_next[AW-1:0];
                        state_next     = (n_sat == '0) ? ST_EMIT : ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                lo_next  = new_lo;
                hi_next  = new_hi;
                mid_next = new_mid;
                if (more) begin
                    rd_addr = new_mid[AW-1:0];
                end else if (ceil_reg) begin
                    res_found_next = (new_lo < n_reg);
                    res_idx_next   = new_lo[AW-1:0];
                    state_next     = ST_EMIT;
                end else if (new_lo != '0) begin
                    rd_addr      = last_le[AW-1:0];
                    res_idx_next = last_le[AW-1:0];
                    state_next   = ST_FLOOR;
                end else begin
                    res_found_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_FLOOR: begin
                // zero mass only counts against a zero key
                res_found_next = (rdata_reg != '0) || (key_reg == '0);
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_idx_next   = res_found_reg ? ridx_wide[INDEX_W-1:0] : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // search and result payload
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        n_reg         <= n_next;
        key_reg       <= key_next;
        ceil_reg      <= ceil_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        m_found_reg   <= m_found_next;
        m_idx_reg     <= m_idx_next;
    end

    // mass table, one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= cmd.value;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W - 1){1'b0}}, m_idx_reg, m_found_reg};

`ifndef ASSERT_OFF
    // probe point stays inside the half-open interval
    a_mid_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("probe index outside search interval");

    // interval never grows past the clamped count
    a_hi_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> (hi_reg <= n_reg) && (n_reg <= CW'(TABLE_DEPTH)))
        else $error("search bound beyond entry count");

    // a reported hit lies among the searched entries
    a_hit_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && res_found_reg |-> ({1'b0, res_idx_reg} < n_reg))
        else $error("hit index beyond entry count");
`endif

endmodule

// ----- hw/rtl/sorted_mass_bound_search.sv -----
// Sorted mass bound search. Table entries are loaded by write items (cmd 0) and searched
// by query items (cmd 1) against the first entry_count entries, which the user keeps
// ascending. Ceiling mode returns the lowest index whose mass is at least the key, floor
// mode the highest index whose mass is at most the key, where a zero mass only matches a
// zero key; found is 0 and match_index 0 when nothing qualifies. Writes give no result.
// Items pass a two-entry queue into a search engine that takes one at a time; a query
// holds the engine until its result is emitted, with one registered read of the table
// per halving step and one more in floor mode. The table is not cleared at reset;
// entries read before being written give undefined answers. The user must write
// entry_count at register address 0 only while idle; the block does not enforce it.
module sorted_mass_bound_search
    import smbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, write_mass, search_key, search_mode (from bit 0 up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                 s_tuser,
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found, match_index (from bit 0 up)
    output logic [M_TDATA_W-1:0] m_tdata,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cfg_we;
    logic               cmd_valid;
    logic               cmd_ready;
    smbs_cmd_t          cmd;

    // register file
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[3:2] == REG_ENTRY_COUNT);

    always_comb begin
        count_next = cfg_we ? pwdata[COUNT_W-1:0] : count_reg;
        prdata     = (paddr[3:2] == REG_ENTRY_COUNT) ? PDATA_W'(count_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // intake and classification
    smbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // table and search engine
    smbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .entry_count (count_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- tb/sorted_mass_bound_search_checker.sv -----
module sorted_mass_bound_search_checker
    import smbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // entry_index, write_mass, search_key, search_mode (from bit 0 up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // found, match_index (from bit 0 up)
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic [PDATA_W-1:0]   prdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   answers_seen,
    output int                   answers_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } answer_t;

    // own copy of the table and the entry count register
    logic [MASS_W-1:0]  masses [DEPTH];
    logic [COUNT_W-1:0] span = '0;
    answer_t            answer_q [$];
    int                 n_fail = 0;
    int                 n_seen = 0;

    initial begin
        for (int i = 0; i < DEPTH; i++) masses[i] = '0;
    end

    function automatic void note_failure(input string msg);
        if (n_fail < 10) $display("mismatch at %0t ns: %s", $time, msg);
        n_fail++;
    endfunction

    // bounded bisection over the searched entries
    function automatic answer_t locate_bound(input logic [MASS_W-1:0] key, input logic mode);
        int unsigned n, lo, hi, mid;
        answer_t     a;
        n  = (span > DEPTH) ? DEPTH : span;
        lo = 0;
        hi = n;
        a  = '0;
        if (mode == MODE_CEILING) begin
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (masses[mid] >= key) hi = mid;
                else lo = mid + 1;
            end
            if (lo < n) begin
                a.found = 1'b1;
                a.index = INDEX_W'(lo);
            end
        end else begin
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (masses[mid] <= key) lo = mid + 1;
                else hi = mid;
            end
            // a zero mass only answers a zero key
            if (lo > 0 && (masses[lo-1] != '0 || key == '0)) begin
                a.found = 1'b1;
                a.index = INDEX_W'(lo - 1);
            end
        end
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            span = '0;
            answer_q.delete();
        end else begin
            // register traffic
            if (psel && penable && pready && paddr == COUNT_ADDR) begin
                if (pwrite) begin
                    span = pwdata[COUNT_W-1:0];
                end else if (prdata !== PDATA_W'(span)) begin
                    note_failure($sformatf("entry_count read expected %0d got %0h",
                                           span, prdata));
                end
            end

            // result items against the oldest expectation
            if (m_tvalid && m_tready) begin
                n_seen++;
                if (answer_q.size() == 0) begin
                    note_failure($sformatf("result item %0h with nothing expected", m_tdata));
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.found)
                        note_failure($sformatf("found expected %0b got %0b",
                                               want.found, m_tdata[0]));
                    if (m_tdata[INDEX_W:1] !== want.index)
                        note_failure($sformatf("match_index expected %0d got %0d",
                                               want.index, m_tdata[INDEX_W:1]));
                    if (m_tdata[M_TDATA_W-1:INDEX_W+1] !== '0)
                        note_failure($sformatf("tdata padding expected 0 got %0h",
                                               m_tdata[M_TDATA_W-1:INDEX_W+1]));
                end
            end

            // input items update the table or queue an answer
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_WRITE)
                    masses[s_tdata[S_INDEX_LSB +: INDEX_W]] = s_tdata[S_MASS_LSB +: MASS_W];
                else
                    answer_q.push_back(locate_bound(s_tdata[S_KEY_LSB +: MASS_W],
                                                    s_tdata[S_MODE_BIT]));
            end
        end
        fail_count   <= n_fail;
        answers_seen <= n_seen;
        answers_owed <= answer_q.size();
    end

endmodule

// ----- tb/sorted_mass_bound_search_test.sv -----
module sorted_mass_bound_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smbs_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 370;
    localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};
    localparam logic [MASS_W-1:0]  MASS_INF   = 31'h7F80_0000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int answers_seen;
    int answers_owed;

    // stimulus side bookkeeping
    logic [MASS_W-1:0] shadow [DEPTH];
    int unsigned       span_now     = 0;
    int                queries_sent = 0;
    logic              steady       = 1'b0;

    sorted_mass_bound_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sorted_mass_bound_search_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .answers_seen (answers_seen),
        .answers_owed (answers_owed)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side stalls, none during a steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // one item on the input channel; valid stays high until the next gap
    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [MASS_W-1:0] mass, input logic [MASS_W-1:0] key,
                             input logic mode);
        while (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({mode, key, mass, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_QUERY) queries_sent++;
        else shadow[idx] = mass;
    endtask

    // unused fields carry random bits
    task automatic write_entry(input int unsigned idx, input logic [MASS_W-1:0] mass);
        send_item(CMD_WRITE, INDEX_W'(idx), mass, MASS_W'($urandom), 1'($urandom));
    endtask

    task automatic ask(input logic [MASS_W-1:0] key, input logic mode);
        send_item(CMD_QUERY, INDEX_W'($urandom), MASS_W'($urandom), key, mode);
    endtask

    // stop sending, wait for every answer, then let a trailing write finish
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (answers_seen < queries_sent) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic count_reg_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= COUNT_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    // new entry count while idle, read back for the checker
    task automatic set_span(input int unsigned n);
        quiesce();
        count_reg_access(1'b1, PDATA_W'(n));
        count_reg_access(1'b0, '0);
        psel     <= 1'b0;
        penable  <= 1'b0;
        span_now = (n > DEPTH) ? DEPTH : n;
    endtask

    function automatic int unsigned extreme_span(input int k);
        case (k)
            0:       return 2047;
            1:       return 1024;
            2:       return 1025;
            3:       return 0;
            4:       return 1;
            5:       return 2;
            default: return 1023;
        endcase
    endfunction

    // keys near stored masses hit equal runs and both sides of each entry
    function automatic logic [MASS_W-1:0] pick_key();
        logic [MASS_W-1:0] v;
        v = shadow[(span_now == 0) ? 0 : $urandom_range(0, span_now - 1)];
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MASS_INF;
            2:       return '1;
            3:       return MASS_W'($urandom);
            4:       return v + 1'b1;
            5:       return v - 1'b1;
            default: return v;
        endcase
    endfunction

    // a mass that keeps the table ascending around idx
    function automatic logic [MASS_W-1:0] fitting_mass(input int unsigned idx);
        logic [MASS_W-1:0] lo;
        logic [MASS_W-1:0] hi;
        lo = (idx > 0) ? shadow[idx-1] : '0;
        hi = (idx < DEPTH - 1) ? shadow[idx+1] : '1;
        if (lo >= hi) return lo;
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            default: return lo + MASS_W'($urandom_range(0, hi - lo));
        endcase
    endfunction

    initial begin
        longint            level;
        int unsigned       n;
        int unsigned       idx;
        int                phase;
        int                burst;
        int                random_items;

        for (int i = 0; i < DEPTH; i++) shadow[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table range: nothing is ever found
        ask('1, MODE_CEILING);
        ask('0, MODE_FLOOR);

        // small ascending table with zeros, an equal run, infinity and nan codes
        write_entry(0, '0);
        write_entry(1, '0);
        write_entry(2, 31'd5);
        write_entry(3, 31'd5);
        write_entry(4, 31'd5);
        write_entry(5, 31'h3F80_0000);
        write_entry(6, MASS_INF);
        write_entry(7, '1);
        write_entry(DEPTH - 1, '1);
        set_span(8);
        ask('0, MODE_CEILING);
        ask('0, MODE_FLOOR);
        ask(31'd3, MODE_FLOOR);
        ask(31'd5, MODE_CEILING);
        ask(31'd5, MODE_FLOOR);
        ask(31'd6, MODE_CEILING);
        ask(MASS_INF, MODE_FLOOR);
        ask(MASS_INF + 1'b1, MODE_CEILING);
        ask('1, MODE_FLOOR);

        // single entry of mass zero
        set_span(1);
        ask('0, MODE_FLOOR);
        ask(31'd1, MODE_CEILING);

        // table no longer ascending
        write_entry(3, 31'd1);
        set_span(7);
        ask('1, MODE_CEILING);
        ask(31'd4, MODE_FLOOR);

        // fill the whole table ascending, with zeros first and repeated masses
        steady <= 1'b1;
        level = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i >= 3 && $urandom_range(0, 4) != 0)
                level = level + $urandom_range(1, 1 << 22);
            if (level > 64'h7FFF_FFFF) level = 64'h7FFF_FFFF;
            write_entry(i, MASS_W'(level));
        end

        // random phases, each under its own entry count
        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase < 7) begin
                n = extreme_span(phase);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: n = $urandom_range(1, 16);
                    4, 5, 6:    n = $urandom_range(17, DEPTH);
                    default:    n = extreme_span($urandom_range(0, 6));
                endcase
            end
            set_span(n);
            steady <= (phase == 3);
            burst = (phase == 3) ? 100 : $urandom_range(15, 40);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 70) begin
                    ask(pick_key(), 1'($urandom));
                end else begin
                    if (span_now > 0 && $urandom_range(0, 3) != 0)
                        idx = $urandom_range(0, span_now - 1);
                    else
                        idx = $urandom_range(0, DEPTH - 1);
                    // a few writes break the ascending order
                    if ($urandom_range(0, 19) == 0) write_entry(idx, MASS_W'($urandom));
                    else write_entry(idx, fitting_mass(idx));
                end
                random_items++;
            end
            phase++;
        end

        quiesce();
        if (fail_count == 0 && answers_owed == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
